[hw/rtl/glyph_bitmap_expander_assert.svh]
// assertion macros used by the glyph expander checker
`ifndef GLYPH_BITMAP_EXPANDER_ASSERT_SVH
`define GLYPH_BITMAP_EXPANDER_ASSERT_SVH

// condition in the same cycle
`define GBE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph expander check failed");

// condition in the following cycle
`define GBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph expander check failed");

`endif

[hw/rtl/gbe_pkg.sv]
// types, constants and helpers of the glyph bitmap expander
package gbe_pkg;

   localparam logic [5:0] MAX_WIDTH = 6'd32;
   localparam logic [5:0] MAX_HEIGHT = 6'd32;
   localparam logic [5:0] WIDTH_RESET = 6'd8;
   localparam logic [5:0] HEIGHT_RESET = 6'd16;
   localparam logic [17:0] STRIDE_RESET = 18'd4096;
   localparam logic [5:0] PIXELS_PER_BYTE = 6'd8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLYPH_WIDTH  = 2'd0,
      CSR_GLYPH_HEIGHT = 2'd1,
      CSR_ROW_STRIDE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  glyph_byte;
      logic        start_req;
      logic [29:0] start_offset;
      logic [31:0] fg_color;
      logic [31:0] bg_color;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_address;
      logic [31:0] pixel_color;
      logic        last_of_byte;
      logic        last_of_glyph;
   } rsp_type;

   // one byte's worth of work handed from front to back
   typedef struct packed {
      logic [7:0]  bits;
      logic [31:0] row_base;
      logic [5:0]  column;
      logic [3:0]  pixel_count;
      logic [31:0] fg;
      logic [31:0] bg;
      logic        glyph_end;
   } job_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [5:0] clamp_dim(logic [5:0] v, logic [5:0] maxv);
      logic [5:0] r;
      r = v;
      if (v == 6'd0) begin
         r = 6'd1;
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

[hw/rtl/gbe_queue.sv]
// short job queue between the front and the back
module gbe_queue
   import gbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   output logic    head_valid,
   output job_type head_data,
   input  logic    pop
);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/gbe_front.sv]
// front: takes register writes and glyph bytes, tracks row and column, turns each byte into a job or drops it
module gbe_front
   import gbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  push,
   output job_type               push_data,
   input  logic                  queue_full
);

   // configuration registers
   logic [5:0]  width_ff, width_in;
   logic [5:0]  height_ff, height_in;
   logic [17:0] stride_ff, stride_in;

   // glyph walk state
   logic        active_ff, active_in;
   logic [5:0]  row_ff, row_in;
   logic [5:0]  col_ff, col_in;
   logic [31:0] base_ff, base_in;
   logic        pend_ff, pend_in;
   logic [17:0] pend_stride_ff, pend_stride_in;
   logic [31:0] fg_ff, fg_in;
   logic [31:0] bg_ff, bg_in;

   logic        accept;
   logic [5:0]  width_eff, height_eff;
   logic        act0, pend0, wrap, drop, row_end, glyph_end;
   logic [5:0]  row0, col0, row1, col1, remain, row_next;
   logic [31:0] base0, base1, fg0, bg0;
   logic [17:0] add_sel;
   logic [3:0]  pixel_count;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign width_eff  = clamp_dim(width_ff, MAX_WIDTH);
   assign height_eff = clamp_dim(height_ff, MAX_HEIGHT);

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GLYPH_WIDTH:  width_in  = csr_data[5:0];
            CSR_GLYPH_HEIGHT: height_in = csr_data[5:0];
            CSR_ROW_STRIDE:   stride_in = csr_data;
            default:          ;
         endcase
      end
   end

   // start overrides the held state
   always_comb begin
      act0  = req_data.start_req || active_ff;
      row0  = req_data.start_req ? 6'd0 : row_ff;
      col0  = req_data.start_req ? 6'd0 : col_ff;
      base0 = req_data.start_req ? {req_data.start_offset, 2'b00} : base_ff;
      pend0 = req_data.start_req ? 1'b0 : pend_ff;
      fg0   = req_data.start_req ? req_data.fg_color : fg_ff;
      bg0   = req_data.start_req ? req_data.bg_color : bg_ff;
   end

   // row advance: a deferred stride from the last row end, or a row cut short by width
   always_comb begin
      wrap = (col0 >= width_eff);
      if (pend0) begin
         add_sel = pend_stride_ff;
      end else if (wrap) begin
         add_sel = stride_ff;
      end else begin
         add_sel = '0;
      end
      base1 = base0 + {14'd0, add_sel};
      col1  = wrap ? 6'd0 : col0;
      row1  = wrap ? row0 + 6'd1 : row0;
   end

   // classify the byte
   always_comb begin
      drop        = !act0 || (row1 >= height_eff);
      remain      = width_eff - col1;
      row_end     = (remain <= PIXELS_PER_BYTE);
      pixel_count = row_end ? remain[3:0] : 4'd8;
      row_next    = row1 + 6'd1;
      glyph_end   = row_end && (row_next >= height_eff);
   end

   // state update on each transaction
   always_comb begin
      active_in      = active_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      base_in        = base_ff;
      pend_in        = pend_ff;
      pend_stride_in = pend_stride_ff;
      fg_in          = fg_ff;
      bg_in          = bg_ff;
      if (accept && act0) begin
         fg_in   = fg0;
         bg_in   = bg0;
         base_in = base1;
         if (drop) begin
            active_in = 1'b0;
            row_in    = row1;
            col_in    = col1;
            pend_in   = 1'b0;
         end else begin
            active_in      = !glyph_end;
            row_in         = row_end ? row_next : row1;
            col_in         = row_end ? 6'd0 : col1 + PIXELS_PER_BYTE;
            pend_in        = row_end;
            pend_stride_in = stride_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         stride_ff <= STRIDE_RESET;
         active_ff <= 1'b0;
         row_ff    <= '0;
         col_ff    <= '0;
         base_ff   <= '0;
         pend_ff   <= 1'b0;
         fg_ff     <= '0;
         bg_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         active_ff <= active_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         base_ff   <= base_in;
         pend_ff   <= pend_in;
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_stride_ff <= pend_stride_in;
   end

   // job handed to the queue
   assign push                  = accept && !drop;
   assign push_data.bits        = req_data.glyph_byte;
   assign push_data.row_base    = base1;
   assign push_data.column      = col1;
   assign push_data.pixel_count = pixel_count;
   assign push_data.fg          = fg0;
   assign push_data.bg          = bg0;
   assign push_data.glyph_end   = glyph_end;

endmodule

[hw/rtl/gbe_back.sv]
// back: expands the head job into one pixel write per cycle while rsp is not stalled, behind an output register
module gbe_back
   import gbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [2:0]  pix_ff, pix_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        emit, last_pix;
   logic [5:0]  col;
   logic [2:0]  bit_sel;

   assign emit     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last_pix = ({1'b0, pix_ff} == head_data.pixel_count - 4'd1);
   assign pop      = emit && last_pix;
   assign col      = head_data.column + {3'd0, pix_ff};
   assign bit_sel  = 3'd7 - pix_ff;

   // next pixel of the head job
   always_comb begin
      rsp_data_in.pixel_address = head_data.row_base + {24'd0, col, 2'b00};
      rsp_data_in.pixel_color   = head_data.bits[bit_sel] ? head_data.fg : head_data.bg;
      rsp_data_in.last_of_byte  = last_pix;
      rsp_data_in.last_of_glyph = last_pix && head_data.glyph_end;
   end

   // pixel counter and output valid
   always_comb begin
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         pix_in       = last_pix ? 3'd0 : pix_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_ff       <= pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/glyph_bitmap_expander.sv]
// Glyph bitmap expander: 1-bit glyph bytes in, 32-bit pixel writes out.
// With the queue empty, a byte is registered in the queue, then its first pixel in the rsp register.
// Throughput: one pixel per cycle while rsp is not stalled; a byte gives 1 to 8 pixels to the
// back expander, and the front takes a byte per cycle while the 2-entry queue has room.
// Reset (synchronous): glyph idle, queue empty, width 8, height 16, stride 4096.
module glyph_bitmap_expander
   import gbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic    push, queue_full, head_valid, pop;
   job_type push_data, head_data;

   // accept and classify
   gbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // job queue
   gbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // pixel expansion
   gbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[hw/rtl/gbe_checker.sv]
// port-level checker for the glyph expander and its bind
`include "glyph_bitmap_expander_assert.svh"

module gbe_checker
   import gbe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled pixel write holds
   `GBE_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // the end of a glyph is also the end of a byte
   `GBE_ASSERT_SAME(a_glyph_end_on_byte_end, clock, reset,
      rsp_valid && rsp_data.last_of_glyph, rsp_data.last_of_byte)

   // pixels of one byte follow without a gap, one word apart
   `GBE_ASSERT_NEXT(a_byte_burst, clock, reset,
      rsp_valid && rsp_ready && !rsp_data.last_of_byte,
      rsp_valid && (rsp_data.pixel_address == $past(rsp_data.pixel_address) + 32'd4))

endmodule

bind glyph_bitmap_expander gbe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[sim/tb_glyph_bitmap_expander.sv]
// testbench for glyph_bitmap_expander: directed script, random glyphs, pixel predictor
module tb_glyph_bitmap_expander;
   import gbe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASES = 8;
   localparam int BYTES_PER_PHASE = 38;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic {STEP_BYTE, STEP_REG} step_kind_type;

   // one line of the directed script: a glyph byte or a register write
   typedef struct packed {
      step_kind_type kind;
      csr_index_type reg_idx;
      logic [17:0]   reg_val;
      req_type       item;
      logic          typed;
      rsp_type       first_px;
   } script_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register shadow
   logic [5:0]  width_reg = WIDTH_RESET;
   logic [5:0]  height_reg = HEIGHT_RESET;
   logic [17:0] stride_reg = STRIDE_RESET;

   // glyph state shadow
   logic        glyph_live = 1'b0;
   int unsigned row_idx = 0;
   int unsigned col_idx = 0;
   logic [31:0] row_addr = '0;
   logic [31:0] held_fg = '0;
   logic [31:0] held_bg = '0;

   rsp_type     pending_pixels[$];
   rsp_type     want_px;
   int          fail_count = 0;
   int          cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   script_step_type script[$];

   glyph_bitmap_expander dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_glyph_bitmap_expander failed");
         $finish;
      end
   end

   // effective glyph dimension: zero counts as one, capped at the maximum
   function automatic int unsigned dim_effective(logic [5:0] v, logic [5:0] cap);
      if (v == 6'd0) return 1;
      if (v > cap) return 32'(cap);
      return 32'(v);
   endfunction

   function automatic void advance_row();
      col_idx = 0;
      row_idx++;
      row_addr = row_addr + 32'(stride_reg);
   endfunction

   // expected pixel writes for one accepted glyph byte
   function automatic void expand_glyph_byte(req_type item);
      int unsigned w;
      int unsigned h;
      int unsigned n;
      logic [7:0]  bits;
      logic        row_done;
      rsp_type     px;
      w = dim_effective(width_reg, MAX_WIDTH);
      h = dim_effective(height_reg, MAX_HEIGHT);
      bits = item.glyph_byte;
      if (item.start_req) begin
         glyph_live = 1'b1;
         row_idx = 0;
         col_idx = 0;
         row_addr = {item.start_offset, 2'b00};
         held_fg = item.fg_color;
         held_bg = item.bg_color;
      end
      if (!glyph_live) return;
      if (col_idx >= w) advance_row();
      if (row_idx >= h) begin
         glyph_live = 1'b0;
         return;
      end
      n = (w - col_idx < 8) ? w - col_idx : 8;
      for (int unsigned k = 0; k < n; k++) begin
         row_done = (col_idx + 1 >= w);
         px.pixel_address = row_addr + 32'(col_idx * 4);
         px.pixel_color = bits[7] ? held_fg : held_bg;
         px.last_of_byte = (k + 1 == n);
         px.last_of_glyph = row_done && (row_idx + 1 >= h);
         bits = bits << 1;
         col_idx++;
         pending_pixels.push_back(px);
         if (row_done) begin
            advance_row();
            if (row_idx >= h) glyph_live = 1'b0;
         end
      end
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // pixel write checker and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel write with none expected: address %h color %h",
                      rsp_data.pixel_address, rsp_data.pixel_color);
               fail_count++;
            end else begin
               want_px = pending_pixels.pop_front();
               check_field("pixel_address", want_px.pixel_address, rsp_data.pixel_address);
               check_field("pixel_color", want_px.pixel_color, rsp_data.pixel_color);
               check_field("last_of_byte", 32'(want_px.last_of_byte),
                           32'(rsp_data.last_of_byte));
               check_field("last_of_glyph", 32'(want_px.last_of_glyph),
                           32'(rsp_data.last_of_glyph));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // send one glyph byte; valid stays up for a following byte
   task automatic push_byte(input req_type item, output int unsigned mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mark = pending_pixels.size();
      expand_glyph_byte(item);
   endtask

   // register write; caller lowers csr_valid after the last one
   task automatic write_reg(input csr_index_type idx, input logic [17:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_GLYPH_WIDTH:  width_reg = value[5:0];
         CSR_GLYPH_HEIGHT: height_reg = value[5:0];
         CSR_ROW_STRIDE:   stride_reg = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // drained, then long enough for dropped bytes to clear the pipeline
   task automatic settle_block();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_type random_item(logic start);
      req_type item;
      item.glyph_byte = 8'($urandom_range(255));
      item.start_req = start;
      item.start_offset = 30'($urandom);
      item.fg_color = $urandom;
      item.bg_color = $urandom;
      return item;
   endfunction

   function automatic script_step_type byte_step(req_type item, logic typed, rsp_type first);
      script_step_type s;
      s = '0;
      s.kind = STEP_BYTE;
      s.item = item;
      s.typed = typed;
      s.first_px = first;
      return s;
   endfunction

   function automatic script_step_type reg_step(csr_index_type idx, logic [17:0] value);
      script_step_type s;
      s = '0;
      s.kind = STEP_REG;
      s.reg_idx = idx;
      s.reg_val = value;
      return s;
   endfunction

   // directed script: extremes, wraps, dropped bytes, shrinking dimensions
   task automatic run_script();
      logic        in_regs;
      int unsigned mark;
      in_regs = 1'b0;
      // idle byte is dropped
      script.push_back(byte_step(req_type'{8'hA5, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      script.push_back(byte_step(req_type'{8'hFF, 1'b1, 30'd0, 32'hFFFF_FFFF, 32'h0},
                                 1'b1, rsp_type'{32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0}));
      script.push_back(byte_step(req_type'{8'h00, 1'b0, 30'h3FFF_FFFF, 32'h0, 32'hFFFF_FFFF},
                                 1'b1, rsp_type'{32'd4096, 32'h0, 1'b0, 1'b0}));
      // start while busy, top offset so the next row wraps
      script.push_back(byte_step(req_type'{8'h80, 1'b1, 30'h3FFF_FFFF, 32'h1234_5678,
                                           32'h9ABC_DEF0},
                                 1'b1, rsp_type'{32'hFFFF_FFFC, 32'h1234_5678, 1'b0, 1'b0}));
      script.push_back(byte_step(req_type'{8'h7E, 1'b0, 30'h0, 32'h0, 32'h0}, 1'b0, '0));
      // zero dimensions act as one pixel
      script.push_back(reg_step(CSR_GLYPH_WIDTH, 18'd0));
      script.push_back(reg_step(CSR_GLYPH_HEIGHT, 18'd0));
      script.push_back(byte_step(req_type'{8'h80, 1'b1, 30'd5, 32'h0000_000A, 32'h0000_000B},
                                 1'b1, rsp_type'{32'd20, 32'h0000_000A, 1'b1, 1'b1}));
      // byte after the glyph finished
      script.push_back(byte_step(req_type'{8'hFF, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      // oversized dimensions cap at the maximum, widest stride
      script.push_back(reg_step(CSR_GLYPH_WIDTH, 18'd63));
      script.push_back(reg_step(CSR_GLYPH_HEIGHT, 18'd63));
      script.push_back(reg_step(CSR_ROW_STRIDE, 18'h3FFFF));
      script.push_back(byte_step(req_type'{8'hC3, 1'b1, 30'd100, 32'hDEAD_BEEF, 32'h0BAD_F00D},
                                 1'b0, '0));
      script.push_back(byte_step(req_type'{8'h3C, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      // width shrinks under the current column
      script.push_back(reg_step(CSR_GLYPH_WIDTH, 18'd4));
      script.push_back(byte_step(req_type'{8'h99, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      // height shrinks under the current row: byte dropped, glyph ends
      script.push_back(reg_step(CSR_GLYPH_HEIGHT, 18'd1));
      script.push_back(byte_step(req_type'{8'hF0, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      // narrow glyph, zero stride, trailing byte dropped
      script.push_back(reg_step(CSR_GLYPH_WIDTH, 18'd3));
      script.push_back(reg_step(CSR_GLYPH_HEIGHT, 18'd2));
      script.push_back(reg_step(CSR_ROW_STRIDE, 18'd0));
      script.push_back(byte_step(req_type'{8'h6A, 1'b1, 30'd7, 32'h5555_5555, 32'hAAAA_AAAA},
                                 1'b0, '0));
      script.push_back(byte_step(req_type'{8'hFF, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      script.push_back(byte_step(req_type'{8'h00, 1'b0, 30'd0, 32'h0, 32'h0}, 1'b0, '0));
      foreach (script[i]) begin
         if (script[i].kind == STEP_REG) begin
            if (!in_regs) begin
               settle_block();
               in_regs = 1'b1;
            end
            write_reg(script[i].reg_idx, script[i].reg_val);
         end else begin
            if (in_regs) begin
               csr_valid <= 1'b0;
               in_regs = 1'b0;
            end
            push_byte(script[i].item, mark);
            if (script[i].typed && pending_pixels.size() > mark)
               pending_pixels[mark] = script[i].first_px;
         end
      end
   endtask

   // random register setting: mostly small glyphs, sometimes the extremes
   task automatic configure_random();
      logic [17:0] w;
      logic [17:0] h;
      logic [17:0] s;
      case ($urandom_range(7))
         0:       w = 18'd0;
         1:       w = 18'd63;
         2:       w = 18'd32;
         default: w = 18'($urandom_range(12, 1));
      endcase
      case ($urandom_range(7))
         0:       h = 18'd0;
         1:       h = 18'd63;
         default: h = 18'($urandom_range(4, 1));
      endcase
      case ($urandom_range(3))
         0:       s = 18'd0;
         1:       s = 18'h3FFFF;
         default: s = 18'($urandom_range(18'h3FFFF));
      endcase
      settle_block();
      write_reg(CSR_GLYPH_WIDTH, w);
      write_reg(CSR_GLYPH_HEIGHT, h);
      write_reg(CSR_ROW_STRIDE, s);
      csr_valid <= 1'b0;
   endtask

   // well-formed glyphs with random content, plus cut, overrun and stray bytes
   task automatic run_phase();
      int          sent;
      int          glyph_len;
      int unsigned mark;
      logic        paused;
      sent = 0;
      paused = 1'b0;
      while (sent < BYTES_PER_PHASE) begin
         if ($urandom_range(99) < 80) begin
            glyph_len = ((dim_effective(width_reg, MAX_WIDTH) + 7) / 8)
                        * dim_effective(height_reg, MAX_HEIGHT);
            if ($urandom_range(9) == 0)
               glyph_len = $urandom_range(glyph_len, 1);
            else if ($urandom_range(9) == 0)
               glyph_len = glyph_len + $urandom_range(2, 1);
            for (int k = 0; k < glyph_len && sent < BYTES_PER_PHASE; k++) begin
               push_byte(random_item(k == 0), mark);
               sent++;
            end
         end else begin
            push_byte(random_item($urandom_range(3) == 0), mark);
            sent++;
         end
         // sender holds off until the output side has caught up
         if (!paused && sent >= BYTES_PER_PHASE / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 15;
      recv_stall_pct = 15;
      run_script();
      for (int p = 0; p < PHASES; p++) begin
         configure_random();
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 85;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct = 15;
               recv_stall_pct = 15;
            end
         endcase
         run_phase();
      end
      settle_block();
      if (fail_count == 0) begin
         $display("tb_glyph_bitmap_expander passed");
      end else begin
         $display("tb_glyph_bitmap_expander failed");
      end
      $finish;
   end

endmodule
